/* rtl/bba_pkg.sv */
// Shared constants, codes and types for the block bitmap allocator.
package bba_pkg;

  localparam int MAP_BITS  = 1024;
  localparam int WORD_BITS = 32;
  localparam int NUM_WORDS = MAP_BITS / WORD_BITS;

  localparam int BLK_W = $clog2(MAP_BITS);
  localparam int CNT_W = BLK_W + 1;
  localparam int WB_W  = $clog2(WORD_BITS);
  localparam int WA_W  = $clog2(NUM_WORDS);
  localparam int K_W   = WA_W + 1;

  localparam logic [1:0] FUNC_ALLOC   = 2'd0;
  localparam logic [1:0] FUNC_FREE    = 2'd1;
  localparam logic [1:0] FUNC_RESERVE = 2'd2;

  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_NOSPACE = 2'd1;
  localparam logic [1:0] STAT_RANGE   = 2'd2;

  localparam logic [CNT_W-1:0] USABLE_RST = CNT_W'(MAP_BITS);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_RMW,
    S_DONE
  } state_t;

  typedef struct packed {
    logic            hit;
    logic [WB_W-1:0] idx;
  } find_res_t;

endpackage

/* rtl/bba_ram.sv */
// Generic simple dual-port RAM with registered read.
module bba_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

/* rtl/bba_find.sv */
// Masked first-free-bit search over one bitmap word.
module bba_find
  import bba_pkg::*;
(
  input  logic [WORD_BITS-1:0] word,
  input  logic [WA_W-1:0]      waddr,
  input  logic                 wrap,
  input  logic [BLK_W-1:0]     start,
  input  logic [CNT_W-1:0]     lim,
  output find_res_t            res
);

  localparam logic [WORD_BITS-1:0] ONES = '1;

  logic [BLK_W-1:0]       lo;
  logic [CNT_W-1:0]       hi;
  logic [WA_W-1:0]        lo_w;
  logic [WB_W-1:0]        lo_b;
  logic [CNT_W-WB_W-1:0]  hi_w;
  logic [WB_W-1:0]        hi_b;
  logic [CNT_W-WB_W-1:0]  w_ext;
  logic [WORD_BITS-1:0]   lo_mask;
  logic [WORD_BITS-1:0]   hi_mask;
  logic [WORD_BITS-1:0]   cand;

  // first pass covers [start, lim), wrap pass covers [0, start)
  assign lo    = wrap ? '0 : start;
  assign hi    = wrap ? {1'b0, start} : lim;
  assign lo_w  = lo[BLK_W-1:WB_W];
  assign lo_b  = lo[WB_W-1:0];
  assign hi_w  = hi[CNT_W-1:WB_W];
  assign hi_b  = hi[WB_W-1:0];
  assign w_ext = {1'b0, waddr};

  always_comb begin
    if (waddr > lo_w) begin
      lo_mask = ONES;
    end else if (waddr == lo_w) begin
      lo_mask = ONES << lo_b;
    end else begin
      lo_mask = '0;
    end
    if (w_ext < hi_w) begin
      hi_mask = ONES;
    end else if (w_ext == hi_w) begin
      hi_mask = ~(ONES << hi_b);
    end else begin
      hi_mask = '0;
    end
  end

  assign cand = ~word & lo_mask & hi_mask;

  always_comb begin
    res.hit = |cand;
    res.idx = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (cand[i]) begin
        res.idx = WB_W'(i);
      end
    end
  end

endmodule

/* rtl/block_bitmap_allocator_hint.sv */
// Top level: block bitmap allocator with next-fit hint search.
//
// One item at a time. Free and reserve read the word at accept, then pass through
// the read-modify-write state (S_RMW) and the state that loads the output
// register (S_DONE); a request rejected as out of range goes straight to S_DONE.
// Allocate scans the bitmap one 32-bit word per cycle through the single read
// port of the bitmap RAM, starting at the hint's word and wrapping back to it,
// and stops at the first free bit, or after revisiting the hint's word
// when no block is free. The bitmap RAM needs no clearing pass:
// a valid bit per word makes unwritten words read as their reset contents.
// The result sits in an output register, so in_ready returns once the result
// is loaded there, before the consumer has taken it.
module block_bitmap_allocator_hint
  import bba_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [1:0]       in_func,
  input  logic [BLK_W-1:0] in_hint,
  input  logic [BLK_W-1:0] in_block,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [1:0]       out_status,
  output logic [BLK_W-1:0] out_block_number,
  output logic [CNT_W-1:0] out_used_count,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CNT_W-1:0] cfg_data
);

  localparam logic [K_W-1:0] K_LAST = K_W'(NUM_WORDS);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAP_BITS);

  state_t state_r, state_nxt;

  logic [CNT_W-1:0] usable_r;
  logic [CNT_W-1:0] lim;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [1:0]       func_r, func_nxt;
  logic [BLK_W-1:0] start_r, start_nxt;
  logic [BLK_W-1:0] blk_r, blk_nxt;
  logic [K_W-1:0]   k_r, k_nxt;
  logic             rq_valid_r, rq_valid_nxt;
  logic             rq_wrap_r, rq_wrap_nxt;
  logic             rq_last_r, rq_last_nxt;
  logic [1:0]       status_r, status_nxt;
  logic [BLK_W-1:0] bno_r, bno_nxt;

  logic             out_valid_r, out_valid_nxt;
  logic [1:0]       out_status_r, out_status_nxt;
  logic [BLK_W-1:0] out_bno_r, out_bno_nxt;
  logic [CNT_W-1:0] out_cnt_r, out_cnt_nxt;

  logic [NUM_WORDS-1:0] row_vld_r;
  logic                 rd_vld_r;
  logic [WA_W-1:0]      rd_addr_q_r;

  logic                 ram_we;
  logic [WA_W-1:0]      ram_waddr;
  logic [WORD_BITS-1:0] ram_wdata;
  logic [WA_W-1:0]      ram_raddr;
  logic [WORD_BITS-1:0] ram_rdata;
  logic [WORD_BITS-1:0] word_eff;
  logic [K_W-1:0]       sum;
  logic [WORD_BITS-1:0] oh_blk;
  logic [WORD_BITS-1:0] oh_hit;
  logic [CNT_W-1:0]     blk_ext;
  find_res_t            fres;

  assign lim     = (usable_r > CNT_MAX) ? CNT_MAX : usable_r;
  assign blk_ext = {1'b0, in_block};

  // unwritten words read as reset contents: block 0 used, rest free
  assign word_eff = rd_vld_r ? ram_rdata :
                    ((rd_addr_q_r == '0) ? WORD_BITS'(1) : '0);

  assign sum    = K_W'({1'b0, start_r[BLK_W-1:WB_W]}) + k_r;
  assign oh_blk = WORD_BITS'(1) << blk_r[WB_W-1:0];
  assign oh_hit = WORD_BITS'(1) << fres.idx;

  bba_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (NUM_WORDS)
  ) u_map (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  bba_find u_find (
    .word  (word_eff),
    .waddr (rd_addr_q_r),
    .wrap  (rq_wrap_r),
    .start (start_r),
    .lim   (lim),
    .res   (fres)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      usable_r    <= USABLE_RST;
      cnt_r       <= CNT_W'(1);
      rq_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      row_vld_r   <= '0;
      rd_vld_r    <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      rq_valid_r  <= rq_valid_nxt;
      out_valid_r <= out_valid_nxt;
      rd_vld_r    <= row_vld_r[ram_raddr];
      if (cfg_valid) begin
        usable_r <= cfg_data;
      end
      if (ram_we) begin
        row_vld_r[ram_waddr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    func_r       <= func_nxt;
    start_r      <= start_nxt;
    blk_r        <= blk_nxt;
    k_r          <= k_nxt;
    rq_wrap_r    <= rq_wrap_nxt;
    rq_last_r    <= rq_last_nxt;
    status_r     <= status_nxt;
    bno_r        <= bno_nxt;
    rd_addr_q_r  <= ram_raddr;
    out_status_r <= out_status_nxt;
    out_bno_r    <= out_bno_nxt;
    out_cnt_r    <= out_cnt_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    func_nxt       = func_r;
    start_nxt      = start_r;
    blk_nxt        = blk_r;
    k_nxt          = k_r;
    rq_valid_nxt   = 1'b0;
    rq_wrap_nxt    = rq_wrap_r;
    rq_last_nxt    = rq_last_r;
    status_nxt     = status_r;
    bno_nxt        = bno_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_status_nxt = out_status_r;
    out_bno_nxt    = out_bno_r;
    out_cnt_nxt    = out_cnt_r;
    ram_we         = 1'b0;
    ram_waddr      = rd_addr_q_r;
    ram_wdata      = word_eff;
    ram_raddr      = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          func_nxt   = in_func;
          blk_nxt    = in_block;
          start_nxt  = ({1'b0, in_hint} < lim) ? in_hint : '0;
          k_nxt      = '0;
          status_nxt = STAT_OK;
          bno_nxt    = '0;
          ram_raddr  = in_block[BLK_W-1:WB_W];
          unique case (in_func)
            FUNC_ALLOC: begin
              state_nxt = S_SCAN;
            end
            FUNC_FREE: begin
              if (in_block == '0 || blk_ext >= lim) begin
                status_nxt = STAT_RANGE;
                state_nxt  = S_DONE;
              end else begin
                state_nxt = S_RMW;
              end
            end
            FUNC_RESERVE: begin
              if (blk_ext >= lim) begin
                status_nxt = STAT_RANGE;
                state_nxt  = S_DONE;
              end else begin
                state_nxt = S_RMW;
              end
            end
            default: begin
              status_nxt = STAT_RANGE;
              state_nxt  = S_DONE;
            end
          endcase
        end
      end

      S_SCAN: begin
        // issue one word read per cycle; the last read revisits the start word
        ram_raddr = sum[WA_W-1:0];
        if (k_r <= K_LAST) begin
          rq_valid_nxt = 1'b1;
          rq_wrap_nxt  = sum[WA_W];
          rq_last_nxt  = (k_r == K_LAST);
          k_nxt        = k_r + K_W'(1);
        end
        if (rq_valid_r) begin
          if (fres.hit) begin
            ram_we       = 1'b1;
            ram_wdata    = word_eff | oh_hit;
            bno_nxt      = {rd_addr_q_r, fres.idx};
            cnt_nxt      = (cnt_r < CNT_MAX) ? cnt_r + CNT_W'(1) : cnt_r;
            rq_valid_nxt = 1'b0;
            state_nxt    = S_DONE;
          end else if (rq_last_r) begin
            status_nxt   = STAT_NOSPACE;
            rq_valid_nxt = 1'b0;
            state_nxt    = S_DONE;
          end
        end
      end

      S_RMW: begin
        ram_we    = 1'b1;
        ram_waddr = blk_r[BLK_W-1:WB_W];
        if (func_r == FUNC_FREE) begin
          // freeing a clear bit still counts down
          ram_wdata = word_eff & ~oh_blk;
          cnt_nxt   = (cnt_r != '0) ? cnt_r - CNT_W'(1) : cnt_r;
        end else begin
          ram_wdata = word_eff | oh_blk;
          if (!word_eff[blk_r[WB_W-1:0]] && cnt_r < CNT_MAX) begin
            cnt_nxt = cnt_r + CNT_W'(1);
          end
        end
        state_nxt = S_DONE;
      end

      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = status_r;
          out_bno_nxt    = bno_r;
          out_cnt_nxt    = cnt_r;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign in_ready         = (state_r == S_IDLE);
  assign cfg_ready        = 1'b1;
  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_block_number = out_bno_r;
  assign out_used_count   = out_cnt_r;

endmodule
